/* design/urrg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the ultrasonic range gate.
// No dependencies; every other file of the block imports this package.
package urrg_pkg;

    localparam int CfgAddrW     = 3;
    localparam int CfgDataW     = 18;
    localparam int TickW        = 16;
    localparam int SinceW       = 18;
    localparam int DistW        = 10;
    localparam int TargetW      = 8;

    localparam logic [TickW-1:0]  TrigLastTick = 16'd10;
    localparam logic [TickW-1:0]  TickFull     = 16'hFFFF;
    localparam logic [SinceW-1:0] SinceMax     = 18'h3FFFF;
    localparam logic [DistW-1:0]  TimeoutCm    = 10'd999;
    localparam logic [10:0]       CmScale      = 11'd1124;
    localparam logic [11:0]       RecipFive    = 12'd3277;   // 2^14 / 5, rounded up
    localparam logic [8:0]        HighClamp    = 9'd255;

    // Configuration register indexes.
    typedef enum logic [CfgAddrW-1:0] {
        REG_ENABLE       = 3'd0,
        REG_TARGET_CM    = 3'd1,
        REG_PING_PERIOD  = 3'd2,
        REG_RISE_TIMEOUT = 3'd3,
        REG_ECHO_MAX     = 3'd4
    } urrg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_MEAS = 2'd3
    } urrg_phase_t;

    typedef struct packed {
        logic               enable;
        logic [TargetW-1:0] target_cm;
        logic [SinceW-1:0]  ping_period;
        logic [TickW-1:0]   rise_timeout;
        logic [TickW-1:0]   echo_max;
    } urrg_cfg_t;

    typedef struct packed {
        logic             timed_out;
        logic [DistW-1:0] distance_cm;
        logic             measured;
        logic             recording;
        logic             trigger_level;
    } urrg_result_t;

    // Exact floor(x / 5) for any 11-bit x (below 2048) by reciprocal multiplication.
    function automatic logic [8:0] div5(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(RecipFive);
        return prod[22:14];
    endfunction

    // Echo width in microsecond ticks to centimetres, saturated at the timeout code.
    function automatic logic [DistW-1:0] ticks_to_cm(input logic [TickW-1:0] width);
        logic [26:0] prod;
        logic [10:0] cm;
        prod = 27'(width) * 27'(CmScale);
        cm   = prod[26:16];
        return (cm > 11'(TimeoutCm)) ? TimeoutCm : cm[DistW-1:0];
    endfunction

endpackage

/* design/urrg_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the ultrasonic range gate.
// Depends on urrg_pkg for the register indexes and the configuration struct.
module urrg_cfg
    import urrg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output urrg_cfg_t           cfg
);

    urrg_cfg_t cfg_reg;
    urrg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENABLE:       cfg_next.enable       = cfg_wdata[0];
                REG_TARGET_CM:    cfg_next.target_cm    = cfg_wdata[TargetW-1:0];
                REG_PING_PERIOD:  cfg_next.ping_period  = cfg_wdata[SinceW-1:0];
                REG_RISE_TIMEOUT: cfg_next.rise_timeout = cfg_wdata[TickW-1:0];
                REG_ECHO_MAX:     cfg_next.echo_max     = cfg_wdata[TickW-1:0];
                default:          cfg_next = cfg_reg;   // unmapped indexes are ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.target_cm    <= '0;
            cfg_reg.ping_period  <= 18'd250000;
            cfg_reg.rise_timeout <= 16'd60000;
            cfg_reg.echo_max     <= 16'd38000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/urrg_core.sv */
`timescale 1ns / 1ps
// Ranging sequencer and record gate: per-tick state update and result.
// Depends on urrg_pkg for the phase type, configuration and result structs.
module urrg_core
    import urrg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  urrg_cfg_t    cfg,
    input  logic         step,        // commit one tick
    input  logic         echo_level,
    output urrg_result_t res
);

    urrg_phase_t        phase_reg, phase_next;
    logic [TickW-1:0]   ticks_reg, ticks_next;
    logic [SinceW-1:0]  since_reg, since_next;
    logic               capture_reg, capture_next;
    logic [DistW-1:0]   dist_reg, dist_next;

    logic [8:0]         thr_low;
    logic [8:0]         thr_high_raw;
    logic [8:0]         thr_high;
    logic               done;
    logic [DistW-1:0]   done_dist;
    urrg_phase_t        phase_eff;

    // Record thresholds: floor(target*4/5) and min(255, floor(target*6/5)).
    assign thr_low      = div5({1'b0, cfg.target_cm, 2'b00});
    assign thr_high_raw = div5(11'({cfg.target_cm, 2'b00}) + 11'({cfg.target_cm, 1'b0}));
    assign thr_high     = (thr_high_raw > HighClamp) ? HighClamp : thr_high_raw;

    always_comb
    begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        since_next   = since_reg;
        capture_next = capture_reg;
        dist_next    = dist_reg;
        done         = 1'b0;
        done_dist    = TimeoutCm;
        phase_eff    = phase_reg;
        res          = '0;

        if (!cfg.enable)
        begin
            phase_next   = PH_IDLE;
            ticks_next   = '0;
            capture_next = 1'b0;
        end
        else
        begin
            // A ping starting now makes this tick the first trigger tick.
            if (phase_reg == PH_IDLE && since_reg > cfg.ping_period)
            begin
                phase_eff  = PH_TRIG;
                since_next = '0;
                ticks_next = '0;
            end

            unique case (phase_eff)
                PH_TRIG:
                begin
                    res.trigger_level = 1'b1;
                    if (ticks_next >= TrigLastTick)
                    begin
                        phase_next = PH_RISE;
                        ticks_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                        ticks_next = ticks_next + 1'b1;
                    end
                end
                PH_RISE:
                begin
                    if (echo_level)
                    begin
                        phase_next = PH_MEAS;
                        ticks_next = 16'd1;
                    end
                    else if (ticks_reg >= cfg.rise_timeout)
                    begin
                        done          = 1'b1;
                        res.timed_out = 1'b1;
                    end
                    else
                    begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                end
                PH_MEAS:
                begin
                    if (echo_level)
                    begin
                        if (ticks_reg > cfg.echo_max || ticks_reg == TickFull)
                        begin
                            done          = 1'b1;
                            res.timed_out = 1'b1;
                        end
                        else
                        begin
                            ticks_next = ticks_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        done      = 1'b1;
                        done_dist = ticks_to_cm(ticks_reg);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (done)
            begin
                dist_next  = done_dist;
                phase_next = PH_IDLE;
                ticks_next = '0;
                if (10'(done_dist) < 10'(thr_low) && !capture_reg)
                    capture_next = 1'b1;
                else if (done_dist > 10'(thr_high) && capture_reg)
                    capture_next = 1'b0;
            end
        end

        // since_next is zero after a ping start, so the count resumes from there.
        if (since_next != SinceMax)
            since_next = since_next + 1'b1;

        res.measured    = done;
        res.recording   = capture_next;
        res.distance_cm = dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ticks_reg   <= '0;
            since_reg   <= '0;
            capture_reg <= 1'b0;
            dist_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            since_reg   <= since_next;
            capture_reg <= capture_next;
            dist_reg    <= dist_next;
        end
    end

    // A timeout is always reported as a completed measurement.
    a_timeout_is_measured: assert property (@(posedge clk) disable iff (!rst_n)
        res.timed_out |-> res.measured)
        else $error("timeout flagged without a completed measurement");

    // A disabled tick leaves the sequencer idle with recording off.
    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.enable |=> phase_reg == PH_IDLE && !capture_reg && ticks_reg == '0)
        else $error("disabled tick did not clear the sequencer");

    // A completed measurement always returns the sequencer to idle.
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.measured |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after a completed measurement");

    // The stored distance never exceeds the timeout code.
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        dist_reg <= TimeoutCm)
        else $error("stored distance out of range");

endmodule

/* design/ultrasonic_range_record_gate_top.sv */
`timescale 1ns / 1ps
// Top level of the ultrasonic range gate: input register, sequencer, result register.
// Depends on urrg_pkg, urrg_cfg and urrg_core.
//
// Usage: every request on the slave channel is one microsecond tick and carries the
// sampled echo pin level in s_tdata bit 0. Each tick yields exactly one request on
// the master channel with the trigger pin level, the recording flag, the measured
// strobe and the last distance in m_tdata, and the timeout flag in m_tuser.
// While enabled, a ping starts once more than ping_period ticks have passed since
// the previous one; the trigger is high for 11 ticks, then the echo rise is awaited
// and the echo pulse is timed. A measurement below floor(4/5 of target_cm) starts
// recording, one above 6/5 of target_cm (at most 255 cm) stops it.
// An accepted tick passes through the input register, where the sequencer state is
// updated, and then through the result register on its way to the master channel.
// While the receiver keeps m_tready high, one tick per cycle is taken; the state
// update for one tick is a single pass of logic between the input register and the
// state and result registers, so nothing else limits the rate below one per clock.
// When the receiver stalls, the result register holds its request, the input
// register holds the next tick, and s_tready drops only once both are full.
// Reset clears the sequencer to idle, recording off, distance zero, and loads the
// register defaults (disabled, ping period 250000, rise timeout 60000, echo max
// 38000). Configuration writes on cfg_we take effect at the next clock edge.
module ultrasonic_range_record_gate_top
    import urrg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write port.
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    // Tick input channel.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [0] echo_level, [7:1] zero
    // Result channel.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [0] trigger_level, [1] recording,
                                           // [2] measured, [12:3] distance_cm, [15:13] zero
    output logic [0:0]          m_tuser    // [0] timed_out
);

    urrg_cfg_t    cfg;
    urrg_result_t res;

    logic         in_valid_reg;
    logic         echo_reg;
    logic         out_valid_reg;
    urrg_result_t out_reg;
    logic         advance;

    urrg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held tick moves on whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    urrg_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (advance),
        .echo_level (echo_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            echo_reg <= s_tdata[0];
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.distance_cm, out_reg.measured,
                       out_reg.recording, out_reg.trigger_level};
    assign m_tuser  = out_reg.timed_out;

    // Every tick that advances out of the input register loads the result register next cycle.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after a tick advanced");

    // Input is refused only when both the input and result registers are occupied.
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input refused with room available");

    // A trigger tick never reports a measurement.
    a_trig_no_meas: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.trigger_level && out_reg.measured))
        else $error("trigger and measurement in the same tick");

endmodule
